// ===== rtl/bmph_pkg.sv =====
// Package for the bar meter peak hold block: payload types, codes and constants.
package bmph_pkg;

  localparam int unsigned NumPartsDefault = 16;
  localparam int unsigned NumRowsDefault  = 16;

  // Peak timing in display ticks
  localparam int unsigned HoldTicks = 16;
  localparam int unsigned FallTicks = 2;
  localparam int unsigned TimerW    = 5;

  // Amplitude to bar height: height = (amplitude * ScaleNum) >> AmpW
  localparam int unsigned AmpW     = 16;
  localparam int unsigned ScaleNum = 70;
  localparam int unsigned ScaleW   = 7;

  localparam int unsigned PartW   = 4;
  localparam int unsigned ColW    = 16;
  localparam int unsigned PeakOutW = 5;
  localparam int unsigned DispW   = 4;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgW    = 4;

  // Configuration register indexes
  typedef enum logic {
    CFG_DISPLAY_TYPE = 1'b0,
    CFG_PEAK_MODE    = 1'b1
  } cfg_idx_e;

  // Peak hold modes
  localparam logic [ModeW-1:0] MODE_NONE     = 2'd0;
  localparam logic [ModeW-1:0] MODE_FALL     = 2'd1;
  localparam logic [ModeW-1:0] MODE_VANISH   = 2'd2;
  localparam logic [ModeW-1:0] MODE_FALL_ALT = 2'd3;

  // Display types
  localparam logic [DispW-1:0] DISP_TYPE_MIN    = 4'd1;
  localparam logic [DispW-1:0] DISP_TYPE_MAX    = 4'd8;
  localparam logic [DispW-1:0] DISP_TYPE_NORMAL = 4'd4;  // last non-inverted type

  typedef struct packed {
    logic [PartW-1:0] part_index;
    logic [AmpW-1:0]  amplitude;
  } in_item_t;

  typedef struct packed {
    logic [PartW-1:0]    part_out;
    logic [ColW-1:0]     column_bits;
    logic [PeakOutW-1:0] peak_row;
  } out_item_t;

  // Control for one peak update
  typedef struct packed {
    logic             en;
    logic [PartW-1:0] part;
    logic [ModeW-1:0] mode;
  } peak_ctl_t;

endpackage

// ===== rtl/bmph_peak.sv =====
// Per-part peak marker store with hold timer, falling flag and update logic.
module bmph_peak #(
  parameter int unsigned NUM_PARTS = bmph_pkg::NumPartsDefault,
  parameter int unsigned LVL_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmph_pkg::peak_ctl_t  ctl_i,
  input  logic [LVL_W-1:0]     height_i,
  output logic [LVL_W-1:0]     peak_o
);

  localparam int unsigned IdxW  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int unsigned PartExtW = 7;
  localparam int unsigned TW = bmph_pkg::TimerW;
  localparam logic [TW-1:0] TimerMax = {TW{1'b1}};

  logic [LVL_W-1:0] level_q   [NUM_PARTS];
  logic [TW-1:0]    timer_q   [NUM_PARTS];
  logic             falling_q [NUM_PARTS];

  logic [PartExtW-1:0] part_ext;
  logic                in_range;
  logic [IdxW-1:0]     idx;
  logic [LVL_W-1:0]    v_cur, v_mid, v_d;
  logic [TW-1:0]       t_cur, t_mid, t_d;
  logic                f_cur, f_mid, f_d;
  logic                do_write;

  assign part_ext = PartExtW'(ctl_i.part);
  assign in_range = part_ext < PartExtW'(NUM_PARTS);
  assign idx      = part_ext[IdxW-1:0];
  assign do_write = ctl_i.en && in_range;

  always_comb begin
    v_cur = in_range ? level_q[idx] : '0;
    t_cur = in_range ? timer_q[idx] : '0;
    f_cur = in_range ? falling_q[idx] : 1'b0;

    // Capture a new peak, or age the held one
    if (v_cur <= height_i) begin
      v_mid = height_i;
      t_mid = '0;
      f_mid = 1'b0;
    end else begin
      v_mid = v_cur;
      t_mid = (t_cur < TimerMax) ? t_cur + TW'(1) : t_cur;
      f_mid = f_cur;
    end

    v_d = v_mid;
    t_d = t_mid;
    f_d = f_mid;
    if (!f_mid && t_mid > TW'(bmph_pkg::HoldTicks) && v_mid != '0) begin
      t_d = '0;
      if (ctl_i.mode == bmph_pkg::MODE_FALL || ctl_i.mode == bmph_pkg::MODE_FALL_ALT) begin
        f_d = 1'b1;
        v_d = v_mid - LVL_W'(1);
      end else begin
        v_d = '0;
      end
    end else if (f_mid && t_mid > TW'(bmph_pkg::FallTicks) && v_mid != '0) begin
      v_d = v_mid - LVL_W'(1);
      t_d = '0;
    end

    peak_o = (in_range && ctl_i.mode != bmph_pkg::MODE_NONE) ? v_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PARTS; p++) begin
        level_q[p]   <= '0;
        timer_q[p]   <= '0;
        falling_q[p] <= 1'b0;
      end
    end else if (do_write) begin
      level_q[idx]   <= v_d;
      timer_q[idx]   <= t_d;
      falling_q[idx] <= f_d;
    end
  end

endmodule

// ===== rtl/bar_meter_peak_hold.sv =====
// Top level of the LED bar meter with per-part peak hold marker.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  input   | in        | in_valid_i / in_stall_o    | in_item_i  (part, amplitude)
//  output  | out       | out_valid_o / out_stall_i  | out_item_o (part, column, peak)
//  config  | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
//  One transaction is accepted per cycle while in_stall_o is low; its result passes
//  through the input register and then the result register. The input register feeds
//  the scale, peak update and row logic, which load the result register; the peak
//  store is written on that same edge. An output stall holds a full result register;
//  the input stalls only when the input register is full as well.
//  rst_ni clears all valid flags and the peak store, and sets display type 1, mode 1.
module bar_meter_peak_hold #(
  parameter int unsigned NUM_PARTS = bmph_pkg::NumPartsDefault,
  parameter int unsigned NUM_ROWS  = bmph_pkg::NumRowsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bmph_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bmph_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  bmph_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [bmph_pkg::CfgW-1:0]     cfg_data_i
);

  // Level width holds 0..NUM_ROWS
  localparam int unsigned LvlW = $clog2(NUM_ROWS + 1);
  // Rows that fit in the column word
  localparam int unsigned ColRows = (NUM_ROWS < bmph_pkg::ColW) ? NUM_ROWS : bmph_pkg::ColW;
  localparam int unsigned ProdW = bmph_pkg::AmpW + bmph_pkg::ScaleW;

  // Configuration registers
  logic [bmph_pkg::DispW-1:0] disp_type_q;
  logic [bmph_pkg::ModeW-1:0] peak_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_type_q <= bmph_pkg::DISP_TYPE_MIN;
      peak_mode_q <= bmph_pkg::MODE_FALL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmph_pkg::CFG_DISPLAY_TYPE: begin
          // Drop writes of illegal types
          if (cfg_data_i inside {[bmph_pkg::DISP_TYPE_MIN:bmph_pkg::DISP_TYPE_MAX]}) begin
            disp_type_q <= cfg_data_i;
          end
        end
        bmph_pkg::CFG_PEAK_MODE: begin
          peak_mode_q <= cfg_data_i[bmph_pkg::ModeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register can take it
  logic                s1_valid_q;
  bmph_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  bmph_pkg::out_item_t out_item_q;
  logic                out_ready;
  logic                s1_move;
  logic                in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  // Scale amplitude to bar height, clamp at the row count
  logic [ProdW-1:0]            prod;
  logic [bmph_pkg::ScaleW-1:0] height_raw;
  logic [LvlW-1:0]             height;

  assign prod       = ProdW'(s1_item_q.amplitude) * ProdW'(bmph_pkg::ScaleNum);
  assign height_raw = prod[ProdW-1:bmph_pkg::AmpW];
  assign height     = (height_raw > bmph_pkg::ScaleW'(NUM_ROWS)) ? LvlW'(NUM_ROWS)
                                                                 : LvlW'(height_raw);

  // Peak marker update for the addressed part
  bmph_pkg::peak_ctl_t peak_ctl;
  logic [LvlW-1:0]     peak;

  assign peak_ctl.en   = s1_move;
  assign peak_ctl.part = s1_item_q.part_index;
  assign peak_ctl.mode = peak_mode_q;

  bmph_peak #(
    .NUM_PARTS (NUM_PARTS),
    .LVL_W     (LvlW)
  ) u_peak (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (peak_ctl),
    .height_i (height),
    .peak_o   (peak)
  );

  // Display type decode
  logic disp_on;
  logic disp_bars;
  logic disp_up;

  assign disp_on   = disp_type_q <= bmph_pkg::DISP_TYPE_NORMAL;
  assign disp_bars = disp_type_q[0];
  assign disp_up   = disp_type_q inside {4'd1, 4'd2, 4'd5, 4'd6};

  // Row pattern: output row i shows level i going up, NUM_ROWS+1-i going down
  logic [bmph_pkg::ColW-1:0] column;

  always_comb begin
    logic [LvlW-1:0] lvl;
    logic            lit;
    column = '0;
    for (int i = 0; i < ColRows; i++) begin
      lvl = disp_up ? LvlW'(i + 1) : LvlW'(NUM_ROWS - i);
      lit = (lvl == LvlW'(1)) || (disp_bars && height > lvl) ||
            (peak != '0 && peak == lvl);
      column[i] = (lit == disp_on);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_item_q.part_out    <= s1_item_q.part_index;
      out_item_q.column_bits <= column;
      out_item_q.peak_row    <= bmph_pkg::PeakOutW'(peak);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Input stall only comes from a full input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // A held item in the input register is not lost while the output stalls
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("input item dropped during output stall");

  // Every result register load comes from a valid input item
  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !s1_valid_q) |=> !out_valid_q)
    else $error("result appeared without an input item");

  // Bottom level is always lit, row one in upward types
  a_bottom_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && disp_up) |=> (out_item_q.column_bits[0] == disp_on))
    else $error("bottom row not lit");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bar meter peak hold block.
`timescale 1ns / 100ps

module tb;
  import bmph_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;  // cycles with no transaction on either side
  localparam int unsigned HoldoffCycles = 80;    // long output hold-off; fills the pipe
  localparam int unsigned PhaseItems    = 225;   // minimum random transactions per register setting
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned TimerMax      = (1 << TimerW) - 1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  // DUT connections; every input is known from time zero
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i    = 1'b0;
  cfg_idx_e   cfg_idx_i   = CFG_DISPLAY_TYPE;
  logic [CfgW-1:0] cfg_data_i = '0;

  bar_meter_peak_hold DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the meter: per-part peak marker state and the two registers
  logic [TimerW-1:0]   peak_lvl  [NumPartsDefault];
  logic [TimerW-1:0]   peak_tmr  [NumPartsDefault];
  logic                peak_fall [NumPartsDefault];
  logic [DispW-1:0]    disp_type = DISP_TYPE_MIN;
  logic [ModeW-1:0]    hold_mode = MODE_FALL;

  in_item_t  pending_ticks[$];   // transactions waiting for the driver
  out_item_t expected_cols[$];   // columns the block still owes

  int unsigned ticks_sent    = 0;
  int unsigned cols_checked  = 0;
  int unsigned input_stalls  = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  logic        in_fired      = 1'b0;  // the offered transaction was taken at the last edge
  logic        holdoff_req   = 1'b0;

  initial begin
    for (int p = 0; p < NumPartsDefault; p++) begin
      peak_lvl[p]  = '0;
      peak_tmr[p]  = '0;
      peak_fall[p] = 1'b0;
    end
  end

  // Advance one part by one display tick and return the column it shows.
  function automatic out_item_t meter_tick(in_item_t tick);
    out_item_t        col;
    logic [22:0]      scaled;
    logic [DispW-1:0] type_off;
    int               height;
    int               lvl;
    int               tmr;
    int               shown;
    int               row_lvl;
    logic             falling;
    logic             lit;
    logic             lit_pol;
    logic             bars;
    logic             upward;
    col      = '0;
    scaled   = tick.amplitude * ScaleNum;
    height   = int'(scaled[22:16]);
    shown    = 0;
    if (height > int'(NumRowsDefault)) height = NumRowsDefault;
    if (tick.part_index < NumPartsDefault) begin
      lvl     = peak_lvl[tick.part_index];
      tmr     = peak_tmr[tick.part_index];
      falling = peak_fall[tick.part_index];
      // Catch a new peak, else let the hold timer run
      if (lvl <= height) begin
        lvl     = height;
        tmr     = 0;
        falling = 1'b0;
      end else if (tmr < int'(TimerMax)) begin
        tmr++;
      end
      // Hold expired: start falling, or drop the marker outright
      if (!falling && tmr > int'(HoldTicks) && lvl > 0) begin
        if (hold_mode == MODE_FALL || hold_mode == MODE_FALL_ALT) begin
          falling = 1'b1;
          lvl--;
        end else begin
          lvl = 0;
        end
        tmr = 0;
      end else if (falling && tmr > int'(FallTicks) && lvl > 0) begin
        lvl--;
        tmr = 0;
      end
      peak_lvl[tick.part_index]  = lvl[TimerW-1:0];
      peak_tmr[tick.part_index]  = tmr[TimerW-1:0];
      peak_fall[tick.part_index] = falling;
      if (hold_mode != MODE_NONE) shown = lvl;
    end
    // Types 1,2,5,6 run upward; 5..8 invert; odd types draw bars
    type_off = disp_type - DISP_TYPE_MIN;
    upward   = !type_off[1];
    lit_pol  = (disp_type <= DISP_TYPE_NORMAL);
    bars     = disp_type[0];
    for (int row = 1; row <= int'(NumRowsDefault); row++) begin
      row_lvl = upward ? row : int'(NumRowsDefault) + 1 - row;
      lit = (row_lvl == 1) || (bars && height > row_lvl) ||
            (shown != 0 && shown == row_lvl);
      if (lit == lit_pol) col.column_bits[row-1] = 1'b1;
    end
    col.part_out = tick.part_index;
    col.peak_row = shown[PeakOutW-1:0];
    return col;
  endfunction

  // Monitor: sample at the rising edge; track register writes, predict on input
  // transactions, check output transactions against the oldest prediction.
  always @(posedge clk_i) begin
    in_fired = in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DISPLAY_TYPE) begin
          // Out-of-range display types leave the register as it was
          if (cfg_data_i >= DISP_TYPE_MIN && cfg_data_i <= DISP_TYPE_MAX)
            disp_type = cfg_data_i[DispW-1:0];
        end else begin
          hold_mode = cfg_data_i[ModeW-1:0];
        end
      end
      if (in_valid_i && in_stall_o) input_stalls++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_cols.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("[%0t] unexpected column: part %0d bits %h peak %0d", $realtime,
                     out_item_o.part_out, out_item_o.column_bits, out_item_o.peak_row);
        end else begin
          out_item_t exp_col;
          exp_col = expected_cols.pop_front();
          cols_checked++;
          if (out_item_o.part_out != exp_col.part_out ||
              out_item_o.column_bits != exp_col.column_bits ||
              out_item_o.peak_row != exp_col.peak_row) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("[%0t] column mismatch: exp part %0d bits %h peak %0d, got part %0d bits %h peak %0d",
                       $realtime, exp_col.part_out, exp_col.column_bits, exp_col.peak_row,
                       out_item_o.part_out, out_item_o.column_bits, out_item_o.peak_row);
          end
        end
      end
      if (in_fired) begin
        expected_cols.insert(expected_cols.size(), meter_tick(in_item_i));
        ticks_sent++;
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Driver: present queued transactions in bursts with random gaps; hold the
  // payload until it is taken.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_ticks.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall on a changing pattern; on request hold off for a long,
  // counted stretch so the block backs up into its input.
  stall_style_e stall_style = STALL_NONE;
  int           style_left  = 0;
  int           holdoff_left = 0;
  int           stall_phase  = 0;
  logic         stall_now;

  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      stall_now = 1'b1;
    end else if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HoldoffCycles - 1;
      stall_now    = 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left  = $urandom_range(30, 200);
      end else begin
        style_left--;
      end
      stall_phase++;
      case (stall_style)
        STALL_NONE:     stall_now = 1'b0;
        STALL_LIGHT:    stall_now = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    stall_now = ($urandom_range(0, 2) != 0);
        default:        stall_now = ((stall_phase % 4) == 0);
      endcase
    end
    out_stall_i <= stall_now;
  end

  task automatic queue_tick(input logic [PartW-1:0] part, input logic [AmpW-1:0] amp);
    in_item_t tick;
    tick.part_index = part;
    tick.amplitude  = amp;
    pending_ticks.insert(pending_ticks.size(), tick);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Hold the sender until everything queued has come back, then let the
  // pipeline settle before touching the registers.
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid_i || expected_cols.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One random phase: mostly peak-then-decay runs per part, so markers hold,
  // fall row by row or vanish; the rest is full-range and threshold noise.
  task automatic queue_phase();
    int unsigned queued;
    int          pick;
    int          run_len;
    logic [PartW-1:0] part;
    logic [AmpW-1:0]  edge_amp [6];
    edge_amp = '{16'h0000, 16'hFFFF, 16'd936, 16'd937, 16'd14979, 16'd14980};
    queued = 0;
    while (queued < PhaseItems) begin
      pick = $urandom_range(0, 99);
      part = PartW'($urandom_range(0, NumPartsDefault - 1));
      if (pick < 60) begin
        run_len = $urandom_range(5, 75);
        queue_tick(part, AmpW'($urandom_range(8000, 65535)));
        queued++;
        for (int k = 0; k < run_len; k++) begin
          // Now and then a tick for some other part lands in the run
          if ($urandom_range(0, 3) == 0)
            queue_tick(PartW'($urandom_range(0, NumPartsDefault - 1)),
                       AmpW'($urandom_range(0, 65535)));
          else
            queue_tick(part, AmpW'($urandom_range(0, 2000)));
          queued++;
        end
      end else if (pick < 85) begin
        queue_tick(part, AmpW'($urandom_range(0, 65535)));
        queued++;
      end else begin
        queue_tick(part, edge_amp[$urandom_range(0, 5)]);
        queued++;
      end
    end
  endtask

  // Display type and hold mode per phase; both extremes of each appear
  logic [DispW-1:0] phase_disp [NumPhases] = '{4'd1, 4'd8, 4'd3, 4'd6, 4'd5, 4'd2, 4'd7, 4'd4};
  logic [ModeW-1:0] phase_mode [NumPhases] = '{MODE_FALL, MODE_NONE, MODE_FALL_ALT, MODE_VANISH,
                                                MODE_FALL, MODE_FALL_ALT, MODE_NONE, MODE_VANISH};

  initial begin
    logic [CfgW-1:0] bad_disp;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at the reset setting: empty and full scale, height
    // thresholds, the last part, and a walking one over the amplitude.
    queue_tick(4'd0, 16'h0000);
    queue_tick(4'd0, 16'hFFFF);
    queue_tick(4'd15, 16'hFFFF);
    queue_tick(4'd15, 16'h0000);
    queue_tick(4'd1, 16'd14979);
    queue_tick(4'd1, 16'd14980);
    queue_tick(4'd2, 16'd936);
    queue_tick(4'd2, 16'd937);
    for (int b = 0; b < AmpW; b++)
      queue_tick(b[PartW-1:0], 16'h0001 << b);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CFG_DISPLAY_TYPE, phase_disp[ph]);
      write_reg(CFG_PEAK_MODE, phase_mode[ph]);
      // Illegal display types (0, 9..15) must be dropped by the block
      bad_disp = (ph == 0) ? 4'd0 : 4'(DISP_TYPE_MAX + ph);
      write_reg(CFG_DISPLAY_TYPE, bad_disp);
      repeat (2) @(negedge clk_i);
      queue_phase();
      if (ph == 2) begin
        // Back-pressure: long output hold-off while the sender keeps offering
        repeat (30) @(negedge clk_i);
        holdoff_req = 1'b1;
      end
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (expected_cols.size() != 0) begin
      error_count += expected_cols.size();
      $display("%0d columns never arrived", expected_cols.size());
    end
    $display("Run: %0d ticks, %0d columns checked over %0d display/hold settings",
             ticks_sent, cols_checked, NumPhases + 1);
    $display("Input held back on %0d cycles; %0d mismatches", input_stalls, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmph_pkg.sv
rtl/bmph_peak.sv
rtl/bar_meter_peak_hold.sv
tb/tb.sv
